/* hdl/scbf_pkg.sv */
// Shared types and constants for the stereo cascaded biquad filter.
`default_nettype none

package scbf_pkg;

  localparam int DEF_MAX_SECTIONS = 16;
  localparam int DEF_SAMPLE_BITS  = 24;
  localparam int DEF_COEF_BITS    = 32;

  // b0, b1, b2, a1, a2
  localparam int SLOTS  = 5;
  localparam int SLOT_W = 3;

  localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int SEC_CNT_W  = 5;
  localparam int SEC_IDX_W  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 2'd0,
    REG_RATE     = 2'd1,
    REG_SECTIONS = 2'd2
  } reg_idx_t;

  localparam logic [1:0] RATE_44K = 2'd0;
  localparam logic [1:0] RATE_48K = 2'd1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_WB,
    ST_FIN
  } st_t;

endpackage

`default_nettype wire

/* hdl/stereo_cascaded_biquad_filter.sv */
// Top level: stereo cascaded direct-form-I biquad filter on one shared multiplier.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid/in_ready, kind, samples, coef_*  | in
//  output  | out_valid/out_ready, left_out, right_out  | out
//  config  | cfg_we, cfg_index, cfg_wdata              | in
//
// Each section runs a history/coef read, 5 multiplies, a final add, and a
// round and write-back on the single multiplier, for each channel of a filtered
// pair over the n sections in use (section_count, at most MAX_SECTIONS);
// pass-through pairs skip the cascade and coefficient writes complete in idle.
// After reset a clearing pass zeroes all 2*MAX_SECTIONS*5 coefficient RAM words
// (160 by default) with in_ready low. A result waiting on out_ready
// stalls only the finish of the next pair.
`default_nettype none

module stereo_cascaded_biquad_filter #(
  parameter int MAX_SECTIONS = scbf_pkg::DEF_MAX_SECTIONS,
  parameter int SAMPLE_BITS  = scbf_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_BITS    = scbf_pkg::DEF_COEF_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               kind,
  input  wire logic signed [SAMPLE_BITS-1:0]      left_in,
  input  wire logic signed [SAMPLE_BITS-1:0]      right_in,
  input  wire logic                               coef_bank,
  input  wire logic [scbf_pkg::SEC_IDX_W-1:0]     coef_section,
  input  wire logic [scbf_pkg::SLOT_W-1:0]        coef_slot,
  input  wire logic signed [COEF_BITS-1:0]        coef_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]           left_out,
  output logic signed [SAMPLE_BITS-1:0]           right_out,
  input  wire logic                               cfg_we,
  input  wire logic [scbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [scbf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import scbf_pkg::*;

  localparam int SB         = SAMPLE_BITS;
  localparam int CB         = COEF_BITS;
  localparam int PROD_W     = SB + CB;
  localparam int ACC_W      = PROD_W + 3;
  localparam int RS         = CB - 4;
  localparam int CA_DEPTH   = 2 * MAX_SECTIONS * SLOTS;
  localparam int CA_W       = $clog2(CA_DEPTH);
  localparam int BSTR       = MAX_SECTIONS * SLOTS;
  localparam int HIST_DEPTH = 2 * MAX_SECTIONS;
  localparam int HA_W       = $clog2(HIST_DEPTH);
  localparam int SEC_W      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W      = $clog2(MAX_SECTIONS + 1);

  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (RS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  st_t state, state_next;

  logic                   enable;
  logic [1:0]             rate_sel;
  logic [SEC_CNT_W-1:0]   sec_count;

  logic [CA_W-1:0]        clr_addr;
  logic [HIST_DEPTH-1:0]  hist_valid;
  logic                   hist_clr;

  logic [SEC_W-1:0]       sec;
  logic                   ch;
  logic [SLOT_W-1:0]      k;
  logic [CA_W-1:0]        coef_base;
  logic signed [SB-1:0]   x_cur;
  logic signed [SB-1:0]   right_hold;
  logic signed [SB-1:0]   left_res;
  logic                   hv;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  // sequencer controls
  logic                   accept;
  logic                   coef_ok;
  logic                   fin_load;
  logic                   filt;
  logic                   last_sec;
  logic [CNT_W-1:0]       n_eff;
  logic [CNT_W-1:0]       sec_ext;

  logic                   cram_we;
  logic [CA_W-1:0]        cram_waddr;
  logic [CB-1:0]          cram_wdata;
  logic [CA_W-1:0]        cram_raddr;
  logic [CB-1:0]          cram_rdata;
  logic [CA_W-1:0]        coef_waddr;

  logic [SEC_W:0]         row_full;
  logic [HA_W-1:0]        row;
  logic                   hram_we;
  logic [4*SB-1:0]        hram_wdata;
  logic [4*SB-1:0]        hram_rdata;

  logic signed [SB-1:0]   tap_x1, tap_x2, tap_y1, tap_y2;
  logic signed [SB-1:0]   mul_a;
  logic signed [ACC_W-1:0] rsum, rsh;
  logic signed [SB-1:0]   y;
  logic [CA_W-1:0]        bank_base;

  scbf_ram #(.WIDTH(CB), .DEPTH(CA_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (cram_we),
    .waddr (cram_waddr),
    .wdata (cram_wdata),
    .raddr (cram_raddr),
    .rdata (cram_rdata)
  );

  scbf_ram #(.WIDTH(4 * SB), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hram_we),
    .waddr (row),
    .wdata (hram_wdata),
    .raddr (row),
    .rdata (hram_rdata)
  );

  // configuration decode
  always_comb begin
    filt = enable && (rate_sel == RATE_44K || rate_sel == RATE_48K) && (sec_count != '0);
    if (32'(sec_count) > MAX_SECTIONS) begin
      n_eff = CNT_W'(MAX_SECTIONS);
    end else begin
      n_eff = CNT_W'(sec_count);
    end
    sec_ext  = CNT_W'(sec);
    last_sec = (CNT_W'(sec_ext + CNT_W'(1)) == n_eff);
    bank_base = rate_sel[0] ? CA_W'(BSTR) : '0;
    coef_ok  = (32'(coef_slot) < SLOTS) && (32'(coef_section) < MAX_SECTIONS);
    coef_waddr = CA_W'((coef_bank ? CA_W'(BSTR) : CA_W'(0))
                       + CA_W'(CA_W'(coef_section) * CA_W'(SLOTS))
                       + CA_W'(coef_slot));
    row_full = {sec, ch};
    row      = row_full[HA_W-1:0];
    // drop all histories on a changed register or an accepted coefficient write
    hist_clr = (cfg_we && ((cfg_index == REG_ENABLE && cfg_wdata[0] != enable)
                        || (cfg_index == REG_RATE && cfg_wdata[1:0] != rate_sel)
                        || (cfg_index == REG_SECTIONS
                            && cfg_wdata[SEC_CNT_W-1:0] != sec_count)))
            || (accept && kind == KIND_COEF && coef_ok);
  end

  // history taps, zero for a row not written since the last clear
  always_comb begin
    tap_x1 = hv ? $signed(hram_rdata[0*SB +: SB]) : '0;
    tap_x2 = hv ? $signed(hram_rdata[1*SB +: SB]) : '0;
    tap_y1 = hv ? $signed(hram_rdata[2*SB +: SB]) : '0;
    tap_y2 = hv ? $signed(hram_rdata[3*SB +: SB]) : '0;
    case (k)
      SLOT_B0: mul_a = x_cur;
      SLOT_B1: mul_a = tap_x1;
      SLOT_B2: mul_a = tap_x2;
      SLOT_A1: mul_a = tap_y1;
      default: mul_a = tap_y2;
    endcase
  end

  // round half up, then saturate
  always_comb begin
    rsum = acc + RND;
    rsh  = rsum >>> RS;
    if (rsh > SAT_HI) begin
      y = SAT_HI[SB-1:0];
    end else if (rsh < SAT_LO) begin
      y = SAT_LO[SB-1:0];
    end else begin
      y = rsh[SB-1:0];
    end
    hram_wdata = {tap_y1, y, tap_x1, x_cur};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == CA_W'(CA_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_COEF) state_next = ST_IDLE;
          else if (filt)         state_next = ST_LOAD;
          else                   state_next = ST_FIN;
        end
      end
      ST_LOAD: state_next = ST_MUL;
      ST_MUL:  if (k == SLOT_W'(SLOTS - 1)) state_next = ST_ACC;
      ST_ACC:  state_next = ST_WB;
      ST_WB:   state_next = (last_sec && ch) ? ST_FIN : ST_LOAD;
      ST_FIN:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready   = 1'b0;
    cram_we    = 1'b0;
    cram_waddr = coef_waddr;
    cram_wdata = coef_value;
    cram_raddr = coef_base;
    hram_we    = 1'b0;
    fin_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cram_we    = 1'b1;
        cram_waddr = clr_addr;
        cram_wdata = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cram_we  = in_valid && (kind == KIND_COEF) && coef_ok;
      end
      ST_MUL: begin
        // fetch the next slot ahead of its multiply, through the registered RAM read
        if (k != SLOT_W'(SLOTS - 1)) cram_raddr = CA_W'(coef_base + CA_W'(k) + CA_W'(1));
      end
      ST_WB:  hram_we  = 1'b1;
      ST_FIN: fin_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      enable     <= 1'b0;
      rate_sel   <= RATE_48K;
      sec_count  <= '0;
      hist_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= CA_W'(clr_addr + CA_W'(1));

      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLE:   enable    <= cfg_wdata[0];
          REG_RATE:     rate_sel  <= cfg_wdata[1:0];
          REG_SECTIONS: sec_count <= cfg_wdata[SEC_CNT_W-1:0];
          default: ;
        endcase
      end

      if (hist_clr) begin
        hist_valid <= '0;
      end else if (state == ST_WB) begin
        hist_valid[row] <= 1'b1;
      end

      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && kind == KIND_SAMPLE) begin
      left_res   <= left_in;
      x_cur      <= filt ? left_in : right_in;
      right_hold <= right_in;
      sec        <= '0;
      ch         <= 1'b0;
      coef_base  <= bank_base;
    end
    unique case (state)
      ST_LOAD: begin
        hv   <= hist_valid[row];
        k    <= '0;
        prod <= '0;
        acc  <= '0;
      end
      ST_MUL: begin
        prod <= mul_a * $signed(cram_rdata);
        acc  <= acc + ACC_W'(prod);
        k    <= SLOT_W'(k + SLOT_W'(1));
      end
      ST_ACC: acc <= acc + ACC_W'(prod);
      ST_WB: begin
        if (last_sec) begin
          sec       <= '0;
          coef_base <= bank_base;
          if (!ch) begin
            left_res <= y;
            x_cur    <= right_hold;
            ch       <= 1'b1;
          end else begin
            x_cur    <= y;
          end
        end else begin
          sec       <= SEC_W'(sec + SEC_W'(1));
          x_cur     <= y;
          coef_base <= CA_W'(coef_base + CA_W'(SLOTS));
        end
      end
      default: ;
    endcase
    if (fin_load) begin
      left_out  <= left_res;
      right_out <= x_cur;
    end
  end

`ifndef ASSERT_OFF
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index == REG_ENABLE && cfg_wdata[0] != enable) |=> (hist_valid == '0))
    else $error("history not cleared on enable change");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (k < SLOT_W'(SLOTS)))
    else $error("slot counter out of range");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FIN))
    else $error("result raised outside finish");

  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WB) |-> (sec_ext < n_eff))
    else $error("section index beyond section count");

  a_wb_to_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WB && !(last_sec && ch)) |=> (state == ST_LOAD))
    else $error("cascade did not advance");
`endif

endmodule

`default_nettype wire

/* hdl/scbf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module scbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
